// File: sv/pei_pkg.sv
// Package for the particle Euler integrator: command codes, register indexes,
// sequencer states and a shared fixed-point saturation helper. No dependencies.
`default_nettype none
package pei_pkg;

  typedef enum logic [1:0] {
    CMD_ADD_FORCE = 2'd0,
    CMD_STEP      = 2'd1,
    CMD_SET_POS   = 2'd2,
    CMD_SET_VEL   = 2'd3
  } cmd_e;

  localparam logic [2:0] REG_TIME_STEP = 3'd0;
  localparam logic [2:0] REG_DAMPING   = 3'd1;
  localparam logic [2:0] REG_INV_MASS  = 3'd2;
  localparam logic [2:0] REG_MASS      = 3'd3;
  localparam logic [2:0] REG_ACCEL_X   = 3'd4;
  localparam logic [2:0] REG_ACCEL_Y   = 3'd5;
  localparam logic [2:0] REG_ACCEL_Z   = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  // Saturate a 34-bit signed sum to 32 bits.
  function automatic logic [31:0] sat_sum(input logic signed [33:0] s);
    logic [31:0] r;
    if (s > 34'sh0_7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if (s < -34'sh0_8000_0000) r = 32'h8000_0000;
    else r = s[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/pei_mul.sv
// Shared 33x33 signed multiplier with a registered product.
// Depends on nothing; the sequencer feeds and consumes it.
`default_nettype none
module pei_mul (
  input  wire logic               clk_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [32:0] b_i,
  output logic signed [65:0]      p_o
);
  // Register one exact product each cycle
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end
endmodule
`default_nettype wire

// File: sv/particle_euler_integrator.sv
// Particle Euler integrator. An item is taken while in_ready_o is high; the block then
// drops in_ready_o and works the item on one shared registered 33x33 multiplier under a
// small sequencer. An integrate step issues 12 products, four per axis. The energy then
// takes 3 squares, one empty slot while the last square lands, and 2 mass products; the
// sequencer then hands the result over and returns to idle. Add-force and set commands,
// and a step while the inverse mass is zero, skip the step products.
// The result is copied into output registers, so the next item may start while it waits.
// A finished item waits only while those registers still hold an unaccepted result.
`default_nettype none
module particle_euler_integrator
  import pei_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] value_x_i,
  input  wire logic [31:0] value_y_i,
  input  wire logic [31:0] value_z_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      position_x_o,
  output logic [31:0]      position_y_o,
  output logic [31:0]      position_z_o,
  output logic [31:0]      velocity_x_o,
  output logic [31:0]      velocity_y_o,
  output logic [31:0]      velocity_z_o,
  output logic [31:0]      kinetic_energy_o,
  output logic             moved_o
);
  localparam int EK = 2 * FRAC_BITS + 1;

  // Configuration registers
  logic [16:0] dt_q, damp_q;
  logic [31:0] imass_q, mass_q;
  logic [31:0] acc_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= 17'd1092;
      damp_q <= 17'd65536;
      imass_q <= 32'd65536;
      mass_q <= 32'd65536;
      acc_q[0] <= '0; acc_q[1] <= '0; acc_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TIME_STEP: dt_q <= cfg_data_i[16:0];
        REG_DAMPING:   damp_q <= cfg_data_i[16:0];
        REG_INV_MASS:  imass_q <= cfg_data_i;
        REG_MASS:      mass_q <= cfg_data_i;
        REG_ACCEL_X:   acc_q[0] <= cfg_data_i;
        REG_ACCEL_Y:   acc_q[1] <= cfg_data_i;
        REG_ACCEL_Z:   acc_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state
  state_e state_q, state_d;
  logic [4:0] step_q, step_d;
  logic [31:0] pos_q [3];
  logic [31:0] vel_q [3];
  logic [31:0] frc_q [3];
  logic [31:0] tmp_q, tmp_d;      // accel component
  logic [31:0] dv_q;              // damped velocity
  logic [66:0] sq_q;              // sum of squares
  logic [99:0] ke_q;              // mass times sum of squares
  logic        moved_q;

  // Result registers
  logic [31:0] res_pos_q [3];
  logic [31:0] res_vel_q [3];
  logic [31:0] res_ke_q;
  logic        res_moved_q;
  logic        out_valid_q;
  logic        res_load;

  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  pei_mul u_mul (.clk_i(clk_i), .a_i(ma), .b_i(mb), .p_o(mp));

  // Round half up and saturate the registered product
  logic signed [65:0] rnd;
  logic [31:0] fx;
  always_comb begin
    rnd = (mp + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (rnd > 66'sh7FFF_FFFF) fx = 32'h7FFF_FFFF;
    else if (rnd < -66'sh8000_0000) fx = 32'h8000_0000;
    else fx = rnd[31:0];
  end

  // Step schedule: products issued at one step are read at the next step.
  // Per axis k (0..2), base 4k: s+0 v*dt, s+1 f*imass, s+2 v*damp, s+3 acc*dt.
  // Energy: steps 12..14 squares, 15 empty while the last square lands,
  // 16..17 mass times low/high halves.
  logic [1:0] ax, ph;
  logic [1:0] rax, rph;
  logic [4:0] rs;
  always_comb begin
    ax = 2'(step_q[4:2]);
    ph = step_q[1:0];
    rs = step_q - 5'd1;
    rax = 2'(rs[4:2]);
    rph = rs[1:0];
    ma = '0; mb = '0;
    if (step_q < 5'd12) begin
      case (ph)
        2'd0: begin ma = 33'(signed'(vel_q[ax])); mb = {16'd0, dt_q}; end
        2'd1: begin ma = 33'(signed'(frc_q[ax])); mb = {1'b0, imass_q}; end
        2'd2: begin ma = 33'(signed'(vel_q[ax])); mb = {16'd0, damp_q}; end
        default: begin ma = 33'(signed'(tmp_q)); mb = {16'd0, dt_q}; end
      endcase
    end else if (step_q < 5'd15) begin
      ma = 33'(signed'(vel_q[2'(step_q - 5'd12)]));
      mb = ma;
    end else if (step_q == 5'd16) begin
      ma = {1'b0, mass_q}; mb = {1'b0, sq_q[31:0]};
    end else if (step_q == 5'd17) begin
      ma = {1'b0, mass_q}; mb = {1'b0, sq_q[63:32]};
    end
  end

  // Next state
  logic step_cmd;
  assign step_cmd = (command_i == CMD_STEP) && (imass_q != 32'd0);
  assign res_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  always_comb begin
    state_d = state_q;
    step_d = step_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) begin
        state_d = ST_RUN;
        step_d = step_cmd ? 5'd0 : 5'd12;
      end
      ST_RUN: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'd18) state_d = ST_DONE;
      end
      ST_DONE: if (res_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= '0;
      moved_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0; vel_q[i] <= '0; frc_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      if (state_q == ST_IDLE && in_valid_i) begin
        moved_q <= step_cmd;
        case (cmd_e'(command_i))
          CMD_ADD_FORCE: begin
            frc_q[0] <= sat_sum(34'(signed'(frc_q[0])) + 34'(signed'(value_x_i)));
            frc_q[1] <= sat_sum(34'(signed'(frc_q[1])) + 34'(signed'(value_y_i)));
            frc_q[2] <= sat_sum(34'(signed'(frc_q[2])) + 34'(signed'(value_z_i)));
          end
          CMD_SET_POS: begin
            pos_q[0] <= value_x_i; pos_q[1] <= value_y_i; pos_q[2] <= value_z_i;
          end
          CMD_SET_VEL: begin
            vel_q[0] <= value_x_i; vel_q[1] <= value_y_i; vel_q[2] <= value_z_i;
          end
          default: ;
        endcase
      end else if (state_q == ST_RUN && moved_q && step_q != 5'd0 && step_q <= 5'd12) begin
        // Retire the product issued last cycle
        case (rph)
          2'd0: pos_q[rax] <= sat_sum(34'(signed'(pos_q[rax])) + 34'(signed'(fx)));
          2'd1: ;
          2'd2: ;
          default: begin
            vel_q[rax] <= sat_sum(34'(signed'(dv_q)) + 34'(signed'(fx)));
            frc_q[rax] <= '0;
          end
        endcase
      end
    end
  end

  // Intermediate and energy datapath
  always_comb begin
    tmp_d = tmp_q;
    if (state_q == ST_RUN && step_q != 5'd0 && step_q <= 5'd12) begin
      case (rph)
        2'd1: tmp_d = sat_sum(34'(signed'(acc_q[rax])) + 34'(signed'(fx)));
        2'd2: tmp_d = fx;
        default: ;
      endcase
    end
  end

  // Damped velocity must not overwrite accel before acc*dt issues: hold the
  // damped velocity separately while accel waits.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN && step_q != 5'd0 && step_q <= 5'd12 && rph == 2'd2) begin
      dv_q <= fx;
    end else begin
      tmp_q <= tmp_d;
    end
    if (state_q == ST_IDLE) begin
      sq_q <= '0;
      ke_q <= '0;
    end else if (state_q == ST_RUN) begin
      if (step_q >= 5'd13 && step_q <= 5'd15) sq_q <= sq_q + 67'(mp[63:0]);
      if (step_q == 5'd17) ke_q <= 100'(mp[63:0]);
      if (step_q == 5'd18) ke_q <= ke_q + {mp[63:0], 32'd0};
    end
  end

  // Final energy rounding and saturation
  logic [99:0] ke_r;
  logic [31:0] ke_o;
  always_comb begin
    ke_r = (ke_q + (100'd1 << (EK - 1))) >> EK;
    if (imass_q == 32'd0) ke_o = '0;
    else if (ke_r > 100'hFFFF_FFFF) ke_o = 32'hFFFF_FFFF;
    else ke_o = ke_r[31:0];
  end

  // Hold the finished result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      res_ke_q <= '0;
      res_moved_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        res_pos_q[i] <= '0; res_vel_q[i] <= '0;
      end
    end else if (res_load) begin
      out_valid_q <= 1'b1;
      res_ke_q <= ke_o;
      res_moved_q <= moved_q;
      for (int i = 0; i < 3; i++) begin
        res_pos_q[i] <= pos_q[i]; res_vel_q[i] <= vel_q[i];
      end
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign position_x_o = res_pos_q[0];
  assign position_y_o = res_pos_q[1];
  assign position_z_o = res_pos_q[2];
  assign velocity_x_o = res_vel_q[0];
  assign velocity_y_o = res_vel_q[1];
  assign velocity_z_o = res_vel_q[2];
  assign kinetic_energy_o = res_ke_q;
  assign moved_o = res_moved_q;

  // Assertions
  a_wait_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_valid_o && !out_ready_i |=> state_q == ST_DONE)
    else $error("result overwritten");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kinetic_energy_o))
    else $error("result dropped");
  a_force_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && moved_o |-> frc_q[0] == '0 && frc_q[2] == '0)
    else $error("force not cleared");
endmodule
`default_nettype wire
